/* hdl/dfu_request_state_machine_defines.svh */
// Assertion macros for the DFU request state machine.
`ifndef DFU_REQUEST_STATE_MACHINE_DEFINES_SVH
`define DFU_REQUEST_STATE_MACHINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dfu_pkg.sv */
// Shared types and constants of the DFU request state machine.
package dfu_pkg;

  localparam int XFER_BYTES   = 64;
  localparam int PAGE_BYTES   = 64;
  localparam int XFER_SHIFT   = $clog2(XFER_BYTES);
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int STATUS_BYTES = 6;
  localparam int MANIFEST_POLL = 100;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_POLL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_POLL = 3'd3;

  localparam logic [31:0] RST_IMAGE_BASE   = 32'd0;
  localparam logic [31:0] RST_FLASH_LIMIT  = 32'd16384;
  localparam logic [7:0]  RST_ERASE_POLL   = 8'd20;
  localparam logic [7:0]  RST_PROGRAM_POLL = 8'd5;

  // request codes
  localparam logic [3:0] CMD_GETSTATUS  = 4'd0;
  localparam logic [3:0] CMD_GETSTATE   = 4'd1;
  localparam logic [3:0] CMD_DNLOAD     = 4'd2;
  localparam logic [3:0] CMD_UPLOAD     = 4'd3;
  localparam logic [3:0] CMD_CLRSTATUS  = 4'd4;
  localparam logic [3:0] CMD_ABORT      = 4'd5;
  localparam logic [3:0] CMD_FLASH_DONE = 4'd7;
  localparam logic [3:0] CMD_VERIFY     = 4'd8;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_VERIFY  = 2'd1;
  localparam logic [1:0] STAT_ADDRESS = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_STATE  = 2'd2;
  localparam logic [1:0] KIND_DATA   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DNLOAD_SYNC = 3'd1,
    ST_DNBUSY      = 3'd2,
    ST_DNLOAD_IDLE = 3'd3,
    ST_MANIFEST    = 3'd4,
    ST_ERROR       = 3'd5
  } dfu_state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_GETSTATUS,
    OP_GETSTATE,
    OP_DNLOAD,
    OP_UPLOAD,
    OP_CLEAR,
    OP_FLASH_DONE,
    OP_VERIFY
  } op_t;

  typedef struct packed {
    logic [31:0] image_base;
    logic [31:0] flash_limit;
    logic [7:0]  erase_poll_ms;
    logic [7:0]  program_poll_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] block_index;
    logic [15:0] req_length;
    logic        verify_ok;
  } dfu_in_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [6:0]  reply_len;
    logic [31:0] read_addr;
    logic [6:0]  capture_len;
    logic        flash_start;
    logic [31:0] flash_addr;
    logic [1:0]  status_code;
    logic [7:0]  poll_ms;
    logic [2:0]  dfu_state;
    logic        reboot_app;
  } dfu_out_t;

  // classified request as it sits in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;       // image_base + block * XFER_BYTES
    logic [31:0] addr_end;   // addr + XFER_BYTES, wrapped
    logic        len_zero;
    logic        len_over;   // longer than one transfer block
    logic [6:0]  len_cap;    // length clipped to one transfer block
    logic [6:0]  rlen_short; // status/state reply length
    logic        verify_ok;
  } q_item_t;

endpackage

/* hdl/dfu_front.sv */
// Front end: takes requests, decodes them and computes block addresses.
module dfu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  dfu_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  dfu_pkg::dfu_in_t in_data,
  output logic             fr_valid,
  input  logic             fr_ready,
  output dfu_pkg::q_item_t fr_item
);
  import dfu_pkg::*;

  logic     valid_r, valid_nxt;
  q_item_t  item_r, item_nxt;
  logic     accept;
  logic [16:0] blk_next;

  assign in_ready = !valid_r || fr_ready;
  assign accept   = in_valid && in_ready;
  assign blk_next = {1'b0, in_data.block_index} + 17'd1;

  always_comb begin
    item_nxt          = '0;
    item_nxt.addr     = cfg.image_base + (32'(in_data.block_index) << XFER_SHIFT);
    item_nxt.addr_end = cfg.image_base + (32'(blk_next) << XFER_SHIFT);
    item_nxt.len_zero = (in_data.req_length == 16'd0);
    item_nxt.len_over = (in_data.req_length > 16'(XFER_BYTES));
    item_nxt.len_cap  = item_nxt.len_over ? 7'(XFER_BYTES) : in_data.req_length[6:0];
    item_nxt.verify_ok = in_data.verify_ok;
    case (in_data.cmd)
      CMD_GETSTATUS: begin
        item_nxt.op = OP_GETSTATUS;
        item_nxt.rlen_short = (in_data.req_length < 16'(STATUS_BYTES)) ?
                              in_data.req_length[6:0] : 7'(STATUS_BYTES);
      end
      CMD_GETSTATE: begin
        item_nxt.op = OP_GETSTATE;
        item_nxt.rlen_short = item_nxt.len_zero ? 7'd0 : 7'd1;
      end
      CMD_DNLOAD:     item_nxt.op = OP_DNLOAD;
      CMD_UPLOAD:     item_nxt.op = OP_UPLOAD;
      CMD_CLRSTATUS:  item_nxt.op = OP_CLEAR;
      CMD_ABORT:      item_nxt.op = OP_CLEAR;
      CMD_FLASH_DONE: item_nxt.op = OP_FLASH_DONE;
      CMD_VERIFY:     item_nxt.op = OP_VERIFY;
      default:        item_nxt.op = OP_NOP;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fr_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign fr_valid = valid_r;
  assign fr_item  = item_r;

endmodule

/* hdl/dfu_queue.sv */
// Short queue between front end and back end.
module dfu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  dfu_pkg::q_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output dfu_pkg::q_item_t pop_item
);
  import dfu_pkg::*;

  q_item_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]    count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/dfu_back.sv */
// Back end: DFU state machine, status registers and reply register.
module dfu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dfu_pkg::cfg_t     cfg,
  input  logic              bk_valid,
  output logic              bk_ready,
  input  dfu_pkg::q_item_t  bk_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dfu_pkg::dfu_out_t out_data
);
  import dfu_pkg::*;

  dfu_state_t  state_r, state_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [31:0] pend_addr_r, pend_addr_nxt;
  logic [6:0]  pend_len_r, pend_len_nxt;
  logic        flash_armed_r, flash_armed_nxt;
  logic        manifest_armed_r, manifest_armed_nxt;
  logic        out_valid_r, out_valid_nxt;
  dfu_out_t    out_r, out_nxt;
  logic        pop;

  // address checks
  logic        dn_bad;
  logic        up_past;
  logic [31:0] up_end;
  logic [31:0] up_room;
  logic [6:0]  up_len;

  assign bk_ready = !out_valid_r || out_ready;
  assign pop      = bk_valid && bk_ready;

  assign dn_bad  = bk_item.len_over || (bk_item.addr < cfg.image_base) ||
                   (bk_item.addr_end > cfg.flash_limit);
  assign up_past = (bk_item.addr >= cfg.flash_limit);
  assign up_end  = bk_item.addr + 32'(bk_item.len_cap);
  assign up_room = cfg.flash_limit - bk_item.addr;
  assign up_len  = up_past ? 7'd0 :
                   (up_end > cfg.flash_limit) ? up_room[6:0] : bk_item.len_cap;

  always_comb begin
    state_nxt          = state_r;
    status_nxt         = status_r;
    poll_nxt           = poll_r;
    pend_addr_nxt      = pend_addr_r;
    pend_len_nxt       = pend_len_r;
    flash_armed_nxt    = flash_armed_r;
    manifest_armed_nxt = manifest_armed_r;
    out_nxt            = '0;
    out_nxt.reply_kind = KIND_ACK;

    case (bk_item.op)
      OP_GETSTATUS: begin
        if (state_r == ST_DNLOAD_SYNC && pend_len_r != '0) begin
          status_nxt      = STAT_OK;
          poll_nxt        = (pend_addr_r[PAGE_SHIFT-1:0] == '0) ?
                            cfg.erase_poll_ms : cfg.program_poll_ms;
          state_nxt       = ST_DNBUSY;
          flash_armed_nxt = 1'b1;
          out_nxt.flash_start = 1'b1;
        end
        out_nxt.reply_kind = KIND_STATUS;
        out_nxt.reply_len  = bk_item.rlen_short;
      end
      OP_GETSTATE: begin
        out_nxt.reply_kind = KIND_STATE;
        out_nxt.reply_len  = bk_item.rlen_short;
      end
      OP_DNLOAD: begin
        if (!bk_item.len_zero) begin
          if (dn_bad) begin
            status_nxt = STAT_ADDRESS;
            state_nxt  = ST_ERROR;
          end else begin
            flash_armed_nxt     = 1'b0;
            pend_addr_nxt       = bk_item.addr;
            pend_len_nxt        = bk_item.len_cap;
            out_nxt.capture_len = bk_item.len_cap;
            state_nxt           = ST_DNLOAD_SYNC;
          end
        end else begin
          // zero-length download ends the image
          status_nxt         = STAT_OK;
          poll_nxt           = 8'(MANIFEST_POLL);
          state_nxt          = ST_MANIFEST;
          manifest_armed_nxt = 1'b1;
        end
      end
      OP_UPLOAD: begin
        out_nxt.reply_kind = KIND_DATA;
        out_nxt.reply_len  = up_len;
        out_nxt.read_addr  = bk_item.addr;
      end
      OP_CLEAR: begin
        state_nxt          = ST_IDLE;
        status_nxt         = STAT_OK;
        poll_nxt           = '0;
        pend_addr_nxt      = '0;
        pend_len_nxt       = '0;
        flash_armed_nxt    = 1'b0;
        manifest_armed_nxt = 1'b0;
      end
      OP_FLASH_DONE: begin
        if (flash_armed_r) begin
          flash_armed_nxt = 1'b0;
          pend_addr_nxt   = '0;
          pend_len_nxt    = '0;
          status_nxt      = STAT_OK;
          poll_nxt        = '0;
          state_nxt       = ST_DNLOAD_IDLE;
        end
      end
      OP_VERIFY: begin
        if (manifest_armed_r) begin
          manifest_armed_nxt = 1'b0;
          if (bk_item.verify_ok) begin
            out_nxt.reboot_app = 1'b1;
          end else begin
            status_nxt = STAT_VERIFY;
            state_nxt  = ST_ERROR;
          end
        end
      end
      default: begin
      end
    endcase

    out_nxt.flash_addr  = pend_addr_nxt;
    out_nxt.status_code = status_nxt;
    out_nxt.poll_ms     = poll_nxt;
    out_nxt.dfu_state   = state_nxt;

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      status_r         <= STAT_OK;
      poll_r           <= '0;
      pend_addr_r      <= '0;
      pend_len_r       <= '0;
      flash_armed_r    <= 1'b0;
      manifest_armed_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (pop) begin
        state_r          <= state_nxt;
        status_r         <= status_nxt;
        poll_r           <= poll_nxt;
        pend_addr_r      <= pend_addr_nxt;
        pend_len_r       <= pend_len_nxt;
        flash_armed_r    <= flash_armed_nxt;
        manifest_armed_r <= manifest_armed_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/dfu_request_state_machine.sv */
// Top level of the DFU request state machine: config registers and the three stages.
//
// Usage
//   in_*  : one decoded control request or event per request (getstatus,
//           getstate, download, upload, clrstatus, abort, flash-write done,
//           manifest verify result); valid/ready.
//   out_* : exactly one reply per request, in request order; valid/ready.
//   cfg_* : write-only register port (image base, flash limit, two poll
//           timeouts); write only while no request is in flight.
// Timing
//   A request passes the decode register (loaded on accept), then one queue
//   slot, then the reply register; out_valid rises when the reply register loads.
//   Throughput is one request per cycle while out_ready stays high. Every path
//   is a decode, one 32-bit add and a handful of 32-bit compares; nothing iterates.
// Reset
//   Synchronous, active low. Clears the DFU state to idle, status to ok,
//   poll timeout, pending block and arm flags, and reloads the config
//   defaults. No clearing pass is needed.
// Back-pressure
//   When out_ready is low the reply register holds; the two-entry queue and
//   the decode register keep filling, then in_ready drops. Nothing is lost.
module dfu_request_state_machine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dfu_pkg::dfu_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dfu_pkg::dfu_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [dfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfu_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dfu_pkg::*;

`include "dfu_request_state_machine_defines.svh"

  cfg_t    cfg_r, cfg_nxt;

  // front end to queue
  logic    fr_valid;
  logic    fr_ready;
  q_item_t fr_item;

  // queue to back end
  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  // reply terms for the checks below
  logic    chk_fstart, chk_busy;
  logic    chk_capture, chk_sync_ack;
  logic    chk_reboot, chk_plain_ack;

  // config register file; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_BASE:   cfg_nxt.image_base      = cfg_wdata;
        REG_FLASH_LIMIT:  cfg_nxt.flash_limit     = cfg_wdata;
        REG_ERASE_POLL:   cfg_nxt.erase_poll_ms   = cfg_wdata[7:0];
        REG_PROGRAM_POLL: cfg_nxt.program_poll_ms = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_base      <= RST_IMAGE_BASE;
      cfg_r.flash_limit     <= RST_FLASH_LIMIT;
      cfg_r.erase_poll_ms   <= RST_ERASE_POLL;
      cfg_r.program_poll_ms <= RST_PROGRAM_POLL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode and address arithmetic
  dfu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_item  (fr_item)
  );

  // decouples decode from execution
  dfu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // DFU state machine and reply register
  dfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .bk_valid  (q_valid),
    .bk_ready  (q_ready),
    .bk_item   (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign chk_fstart    = out_valid && out_data.flash_start;
  assign chk_busy      = (out_data.dfu_state == ST_DNBUSY);
  assign chk_capture   = out_valid && (out_data.capture_len != 7'd0);
  assign chk_sync_ack  = (out_data.dfu_state == ST_DNLOAD_SYNC) &&
                         (out_data.reply_kind == KIND_ACK);
  assign chk_reboot    = out_valid && out_data.reboot_app;
  assign chk_plain_ack = (out_data.reply_kind == KIND_ACK) && !out_data.flash_start &&
                         (out_data.capture_len == 7'd0);

  // a flash write is only ever armed on the way into dnbusy
  `DFU_ASSERT_NOW(a_fstart_busy, chk_fstart, chk_busy, "flash_start outside dnbusy")
  // payload capture only on a clean download, which lands in dnload_sync
  `DFU_ASSERT_NOW(a_capture_sync, chk_capture, chk_sync_ack, "capture outside dnload_sync")
  // a passed verify only raises reboot on a plain ack
  `DFU_ASSERT_NOW(a_reboot_ack, chk_reboot, chk_plain_ack, "reboot on a non-ack reply")
  // a decoded request pushed into the queue is visible to the back end next cycle
  `DFU_ASSERT_NEXT(a_queue_push, fr_valid && fr_ready, q_valid, "queue push lost")

endmodule

/* tb/tb_dfu_request_state_machine.sv */
// Self-checking testbench for the DFU request state machine, with its reply scoreboard.
module tb_dfu_request_state_machine;
  timeunit 1ns;
  timeprecision 1ps;

  import dfu_pkg::*;

  // Codes the package leaves unnamed: "other" request and the top of the 4-bit code space.
  localparam logic [3:0] CMD_OTHER = 4'd6;
  localparam logic [3:0] CMD_TOP   = 4'hF;

  localparam int NUM_SETTINGS = 6;
  localparam int PHASE_ITEMS  = 75;
  localparam int CYCLE_LIMIT  = 200_000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_LONG} rx_mode_t;

  // ---------------------------------------------------------------------------
  // Reply scoreboard: mirrors the DFU machine and queues one reply per request.
  // ---------------------------------------------------------------------------
  class dfu_reply_scoreboard;
    cfg_t        cfg;
    dfu_state_t  cur_state;
    logic [1:0]  cur_status;
    logic [7:0]  cur_poll;
    logic [31:0] blk_addr;
    logic [6:0]  blk_len;
    logic        write_armed;
    logic        image_armed;

    dfu_out_t awaited_replies[$];
    int failures;
    int n_requests;
    int n_replies;
    int n_writes_armed;
    int n_reboots;
    int n_errors_entered;

    function new();
      cfg = '{RST_IMAGE_BASE, RST_FLASH_LIMIT, RST_ERASE_POLL, RST_PROGRAM_POLL};
      clear_state();
      failures = 0;
      n_requests = 0;
      n_replies = 0;
      n_writes_armed = 0;
      n_reboots = 0;
      n_errors_entered = 0;
    endfunction

    function void clear_state();
      cur_state   = ST_IDLE;
      cur_status  = STAT_OK;
      cur_poll    = '0;
      blk_addr    = '0;
      blk_len     = '0;
      write_armed = 1'b0;
      image_armed = 1'b0;
    endfunction

    // Narrow registers keep only their low byte.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_BASE:   cfg.image_base      = data;
        REG_FLASH_LIMIT:  cfg.flash_limit     = data;
        REG_ERASE_POLL:   cfg.erase_poll_ms   = data[7:0];
        REG_PROGRAM_POLL: cfg.program_poll_ms = data[7:0];
        default: ;
      endcase
    endfunction

    function dfu_out_t predict_reply(dfu_in_t r);
      dfu_out_t    o;
      logic [31:0] a;
      logic [31:0] a_end;
      logic [6:0]  n;
      o = '0;
      a = cfg.image_base + (32'(r.block_index) << XFER_SHIFT);
      case (r.cmd)
        CMD_GETSTATUS: begin
          if (cur_state == ST_DNLOAD_SYNC && blk_len != 0) begin
            cur_status  = STAT_OK;
            cur_poll    = (blk_addr[PAGE_SHIFT-1:0] == 0) ? cfg.erase_poll_ms
                                                         : cfg.program_poll_ms;
            cur_state   = ST_DNBUSY;
            write_armed = 1'b1;
            o.flash_start = 1'b1;
            n_writes_armed++;
          end
          o.reply_kind = KIND_STATUS;
          o.reply_len  = (r.req_length < STATUS_BYTES) ? r.req_length[6:0]
                                                      : 7'(STATUS_BYTES);
        end
        CMD_GETSTATE: begin
          o.reply_kind = KIND_STATE;
          o.reply_len  = (r.req_length == 0) ? 7'd0 : 7'd1;
        end
        CMD_DNLOAD: begin
          if (r.req_length != 0) begin
            a_end = a + 32'(XFER_BYTES);
            if (r.req_length > XFER_BYTES || a < cfg.image_base || a_end > cfg.flash_limit) begin
              cur_status = STAT_ADDRESS;
              cur_state  = ST_ERROR;
              n_errors_entered++;
            end else begin
              write_armed   = 1'b0;
              blk_addr      = a;
              blk_len       = r.req_length[6:0];
              o.capture_len = r.req_length[6:0];
              cur_state     = ST_DNLOAD_SYNC;
            end
          end else begin
            // zero-length download closes the image
            cur_status  = STAT_OK;
            cur_poll    = 8'(MANIFEST_POLL);
            cur_state   = ST_MANIFEST;
            image_armed = 1'b1;
          end
        end
        CMD_UPLOAD: begin
          n = (r.req_length < XFER_BYTES) ? r.req_length[6:0] : 7'(XFER_BYTES);
          if (a >= cfg.flash_limit) n = '0;
          else if (a + 32'(n) > cfg.flash_limit) n = 7'(cfg.flash_limit - a);
          o.reply_kind = KIND_DATA;
          o.reply_len  = n;
          o.read_addr  = a;
        end
        CMD_CLRSTATUS, CMD_ABORT: clear_state();
        CMD_FLASH_DONE: begin
          if (write_armed) begin
            write_armed = 1'b0;
            blk_addr    = '0;
            blk_len     = '0;
            cur_status  = STAT_OK;
            cur_poll    = '0;
            cur_state   = ST_DNLOAD_IDLE;
          end
        end
        CMD_VERIFY: begin
          if (image_armed) begin
            image_armed = 1'b0;
            if (r.verify_ok) begin
              o.reboot_app = 1'b1;
              n_reboots++;
            end else begin
              cur_status = STAT_VERIFY;
              cur_state  = ST_ERROR;
              n_errors_entered++;
            end
          end
        end
        default: ;
      endcase
      o.flash_addr  = blk_addr;
      o.status_code = cur_status;
      o.poll_ms     = cur_poll;
      o.dfu_state   = cur_state;
      return o;
    endfunction

    function void note_request(dfu_in_t r);
      n_requests++;
      awaited_replies.push_back(predict_reply(r));
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_reply(dfu_out_t got);
      dfu_out_t want;
      n_replies++;
      if (awaited_replies.size() == 0) begin
        $error("reply with no request waiting: 0x%0h", got);
        failures++;
        return;
      end
      want = awaited_replies.pop_front();
      cmp_field("reply_kind",  want.reply_kind,  got.reply_kind);
      cmp_field("reply_len",   want.reply_len,   got.reply_len);
      cmp_field("read_addr",   want.read_addr,   got.read_addr);
      cmp_field("capture_len", want.capture_len, got.capture_len);
      cmp_field("flash_start", want.flash_start, got.flash_start);
      cmp_field("flash_addr",  want.flash_addr,  got.flash_addr);
      cmp_field("status_code", want.status_code, got.status_code);
      cmp_field("poll_ms",     want.poll_ms,     got.poll_ms);
      cmp_field("dfu_state",   want.dfu_state,   got.dfu_state);
      cmp_field("reboot_app",  want.reboot_app,  got.reboot_app);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dfu_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dfu_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dfu_request_state_machine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dfu_reply_scoreboard sb = new();

  int n_issued = 0;
  int burst_left = 0;
  int cycle_count = 0;
  cfg_t settings [NUM_SETTINGS];

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the DUT's
  // registers update, so handshakes seen here are exactly the accepted ones.
  // Register writes go to the mirror at the same edge the DUT takes them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_reply(out_data);
    end
  end

  // Hard stop in case the DUT hangs or drops a request.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Reply side back-pressure. The mode is redrawn each time the 7-bit tick counter
  // wraps: wide open, coin flip, a fixed comb on the low tick bits, or rare long
  // stalls.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  logic [6:0] rx_tick = '0;
  int rx_hold = 0;

  always @(negedge clk) begin
    rx_tick <= rx_tick + 7'd1;
    if (rx_tick == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom);
      RX_COMB: out_ready <= (rx_tick[2:0] != 3'd2) && (rx_tick[2:0] != 3'd5);
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          out_ready <= 1'b0;
          rx_hold   <= $urandom_range(1, 11);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------
  function automatic dfu_in_t req(logic [3:0] c, logic [15:0] idx, logic [15:0] len,
                                  logic ok);
    dfu_in_t r;
    r.cmd         = c;
    r.block_index = idx;
    r.req_length  = len;
    r.verify_ok   = ok;
    return r;
  endfunction

  // Block number that lands fully inside [image_base, flash_limit); falls back
  // to any number when the window cannot hold a single block.
  function automatic logic [15:0] good_block();
    logic [31:0] first_end;
    logic [31:0] top;
    first_end = sb.cfg.image_base + 32'(XFER_BYTES);
    if (first_end < sb.cfg.image_base || sb.cfg.flash_limit < first_end) return 16'($urandom);
    top = (sb.cfg.flash_limit - first_end) >> XFER_SHIFT;
    if (top > 32'hFFFF) top = 32'hFFFF;
    if ($urandom_range(0, 5) == 0) return 16'(top);
    return 16'($urandom_range(0, top));
  endfunction

  // Block number right around the flash limit, for clipped uploads.
  function automatic logic [15:0] boundary_block();
    logic [31:0] span;
    span = sb.cfg.flash_limit - sb.cfg.image_base;
    return 16'(span >> XFER_SHIFT) + 16'($urandom_range(0, 2)) - 16'd1;
  endfunction

  // Sends one request. The sender works in bursts: when a burst runs out it
  // drops valid for a random gap and picks a new burst length, sometimes a
  // long one so that stretches with no idling show up too. Called and
  // returning at a falling edge; valid stays high between back-to-back
  // requests.
  task automatic issue(input dfu_in_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_issued++;
  endtask

  // Every request yields one reply, so an empty scoreboard means idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(negedge clk);
  endtask

  // Writes all four registers, then a spare index with junk that must be
  // ignored. The upper bits of the poll writes carry junk as well.
  task automatic program_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_IMAGE_BASE, REG_FLASH_LIMIT, REG_ERASE_POLL, REG_PROGRAM_POLL,
            REG_PROGRAM_POLL + 3'($urandom_range(1, 4))};
    val = '{c.image_base, c.flash_limit, {24'($urandom), c.erase_poll_ms},
            {24'($urandom), c.program_poll_ms}, 32'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most of it is well-formed DFU exchanges so the machine
  // gets past idle: download / status poll / flash done, manifest / verify,
  // and uploads near the end of flash. The rest is clears and pure noise
  // over the whole code space and all field bits.
  task automatic run_random(input int quota);
    int stop;
    int pick;
    stop = n_issued + quota;
    while (n_issued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        issue(req(CMD_DNLOAD, good_block(), 16'($urandom_range(1, XFER_BYTES)), 1'($urandom)));
        if ($urandom_range(0, 2) == 0)
          issue(req(CMD_GETSTATE, 16'($urandom), 16'($urandom_range(0, 2)), 1'($urandom)));
        issue(req(CMD_GETSTATUS, 16'($urandom), 16'($urandom_range(0, 8)), 1'($urandom)));
        if ($urandom_range(0, 3) == 0)
          issue(req(CMD_GETSTATUS, 16'($urandom), 16'($urandom), 1'($urandom)));
        if ($urandom_range(0, 9) != 0)
          issue(req(CMD_FLASH_DONE, 16'($urandom), 16'($urandom), 1'($urandom)));
      end else if (pick < 60) begin
        issue(req(CMD_DNLOAD, 16'($urandom), 16'd0, 1'($urandom)));
        if ($urandom_range(0, 1) == 0)
          issue(req(CMD_GETSTATUS, 16'($urandom), 16'($urandom_range(0, 8)), 1'($urandom)));
        issue(req(CMD_VERIFY, 16'($urandom), 16'($urandom), 1'($urandom)));
      end else if (pick < 72) begin
        issue(req(CMD_UPLOAD, ($urandom_range(0, 1) == 0) ? boundary_block() : 16'($urandom),
                  16'($urandom_range(0, 80)), 1'($urandom)));
      end else if (pick < 80) begin
        issue(req(($urandom_range(0, 1) == 0) ? CMD_CLRSTATUS : CMD_ABORT,
                  16'($urandom), 16'($urandom), 1'($urandom)));
      end else begin
        issue(req(4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Register settings per phase: reset defaults, an unaligned base (program
    // poll path, clipped uploads), top-of-space windows where block addresses
    // wrap, an empty window, and one drawn at random.
    settings[0] = '{RST_IMAGE_BASE, RST_FLASH_LIMIT, RST_ERASE_POLL, RST_PROGRAM_POLL};
    settings[1] = '{32'h1000_0024, 32'h1000_2011, 8'hFF, 8'h00};
    settings[2] = '{32'hFFFF_0000, 32'hFFFF_FFFF, 8'h00, 8'hFF};
    settings[3] = '{32'hFFFF_FFC0, 32'hFFFF_FFFF, 8'h80, 8'h7F};
    settings[4] = '{32'h0000_0000, 32'h0000_0000, 8'h01, 8'hFE};
    settings[5].image_base      = 32'($urandom);
    settings[5].flash_limit     = settings[5].image_base + 32'($urandom_range(64, 1 << 22));
    settings[5].erase_poll_ms   = 8'($urandom);
    settings[5].program_poll_ms = 8'($urandom);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass on reset defaults.
    issue(req(CMD_GETSTATUS, 16'd0, 16'd0, 1'b0));           // idle status, zero length
    issue(req(CMD_GETSTATE, 16'hFFFF, 16'hFFFF, 1'b1));      // longest length, one byte back
    issue(req(CMD_UPLOAD, 16'd0, 16'd64, 1'b0));
    issue(req(CMD_UPLOAD, 16'd255, 16'hFFFF, 1'b0));         // last block before the limit
    issue(req(CMD_UPLOAD, 16'd256, 16'd16, 1'b0));           // at the limit: nothing
    issue(req(CMD_FLASH_DONE, 16'd0, 16'd0, 1'b0));          // no write armed: plain ack
    issue(req(CMD_VERIFY, 16'd0, 16'd0, 1'b1));              // no manifest armed: plain ack
    issue(req(CMD_DNLOAD, 16'd0, 16'd1, 1'b0));              // block at address zero
    issue(req(CMD_GETSTATE, 16'd0, 16'd1, 1'b0));
    issue(req(CMD_GETSTATUS, 16'd0, 16'd6, 1'b0));           // arms the write
    issue(req(CMD_GETSTATUS, 16'd0, 16'd6, 1'b0));           // busy, no second arm
    issue(req(CMD_FLASH_DONE, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_DNLOAD, 16'd255, 16'd64, 1'b0));           // full block, last slot
    issue(req(CMD_GETSTATUS, 16'd0, 16'd255, 1'b0));
    issue(req(CMD_FLASH_DONE, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_DNLOAD, 16'd1, 16'd65, 1'b0));             // too long
    issue(req(CMD_CLRSTATUS, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_DNLOAD, 16'hFFFF, 16'd1, 1'b0));           // past flash end
    issue(req(CMD_ABORT, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_DNLOAD, 16'd0, 16'd0, 1'b0));              // enter manifest
    issue(req(CMD_VERIFY, 16'd0, 16'd0, 1'b0));              // image check fails
    issue(req(CMD_CLRSTATUS, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_DNLOAD, 16'd0, 16'd0, 1'b0));
    issue(req(CMD_VERIFY, 16'd0, 16'd0, 1'b1));              // image check passes: reboot
    issue(req(CMD_OTHER, 16'hFFFF, 16'hFFFF, 1'b1));
    issue(req(CMD_TOP, 16'hFFFF, 16'hFFFF, 1'b1));           // undefined code

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p != 0) begin
        settle();
        program_regs(settings[p]);
      end
      run_random(PHASE_ITEMS);
    end

    // Drain, then give the pipeline time to show any stray reply.
    settle();
    repeat (8) @(negedge clk);

    $display("Run covered %0d requests over %0d register settings, %0d replies checked.",
             sb.n_requests, NUM_SETTINGS, sb.n_replies);
    $display("Block writes armed: %0d, error entries: %0d, reboots: %0d.",
             sb.n_writes_armed, sb.n_errors_entered, sb.n_reboots);
    if (sb.failures == 0 && sb.awaited_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
